/* rtl/core/tlbpt_pkg.sv */
package tlbpt_pkg;

  localparam int TLB_ENTRIES_DEF = 16;
  localparam int PAGE_COUNT_DEF  = 256;
  localparam int OFFSET_BITS_DEF = 8;

  localparam int ADDR_W  = 16;
  localparam int FRAME_W = 8;
  localparam int COUNT_W = 16;

  // front-end capacity: two address stages plus the queue share this budget
  localparam int QUEUE_DEPTH = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_FETCH,
    ST_RESOLVE
  } back_state_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_status_t;

endpackage

/* rtl/core/tlbpt_ram.sv */
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/tlbpt_front.sv */
module tlbpt_front
  import tlbpt_pkg::*;
#(
  parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ADDR_W-1:0]             vaddr,
  output logic                          head_valid,
  output logic [$clog2(PAGE_COUNT)-1:0] head_page,
  output logic [OFFSET_BITS-1:0]        head_offset,
  input  back_status_t                  status
);

  localparam int PAGE_W  = $clog2(PAGE_COUNT);
  localparam int RAW_W   = ADDR_W + 1 - OFFSET_BITS;
  localparam int SHIFT   = RAW_W + PAGE_W;
  localparam int RECIP   = ((1 << SHIFT) + PAGE_COUNT - 1) / PAGE_COUNT;
  localparam int PROD_W  = 2 * RAW_W + 1;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

  logic                   accept;
  logic [CNT_W-1:0]       inflight;
  logic [CNT_W-1:0]       q_cnt;

  logic                   sa_valid;
  logic [RAW_W-1:0]       sa_raw;
  logic [OFFSET_BITS-1:0] sa_off;

  logic                   sb_valid;
  logic [RAW_W-1:0]       sb_raw;
  logic [RAW_W-1:0]       sb_q;
  logic [OFFSET_BITS-1:0] sb_off;

  logic [PROD_W-1:0]      recip_prod;
  logic [SHIFT-1:0]       q_times_p;
  logic [PAGE_W-1:0]      push_page;

  logic [PAGE_W-1:0]      q_page [QUEUE_DEPTH];
  logic [OFFSET_BITS-1:0] q_off  [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wr_ptr;
  logic [QPTR_W-1:0]      rd_ptr;

  assign busy   = status.clearing || (inflight == CNT_W'(QUEUE_DEPTH));
  assign accept = start && !busy;

  // page mod PAGE_COUNT by reciprocal multiply; exact over the whole raw page range
  assign recip_prod = PROD_W'(sa_raw) * PROD_W'(RECIP);
  assign q_times_p  = SHIFT'(sb_q) * SHIFT'(PAGE_COUNT);
  assign push_page  = PAGE_W'(sb_raw - RAW_W'(q_times_p));

  assign head_valid  = (q_cnt != '0);
  assign head_page   = q_page[rd_ptr];
  assign head_offset = q_off[rd_ptr];

  always_ff @(posedge clk) begin
    sa_raw <= RAW_W'({1'b0, vaddr} >> OFFSET_BITS);
    sa_off <= vaddr[OFFSET_BITS-1:0];
    sb_raw <= sa_raw;
    sb_q   <= RAW_W'(recip_prod >> SHIFT);
    sb_off <= sa_off;
    if (sb_valid) begin
      q_page[wr_ptr] <= push_page;
      q_off[wr_ptr]  <= sb_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
      sb_valid <= 1'b0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      q_cnt    <= '0;
      inflight <= '0;
    end else begin
      sa_valid <= accept;
      sb_valid <= sa_valid;
      if (sb_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (status.pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      q_cnt    <= q_cnt + CNT_W'(sb_valid) - CNT_W'(status.pop);
      inflight <= inflight + CNT_W'(accept) - CNT_W'(status.pop);
    end
  end

endmodule

/* rtl/core/tlbpt_back.sv */
module tlbpt_back
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  logic [$clog2(PAGE_COUNT)-1:0] head_page,
  input  logic [OFFSET_BITS-1:0]        head_offset,
  output back_status_t                  status,
  output logic                          done,
  output logic [ADDR_W-1:0]             paddr,
  output logic [FRAME_W-1:0]            frame_number,
  output logic                          tlb_hit,
  output logic                          page_fault,
  output logic [COUNT_W-1:0]            hit_total,
  output logic [COUNT_W-1:0]            fault_total
);

  localparam int PAGE_W = $clog2(PAGE_COUNT);
  localparam int TIDX_W = $clog2(TLB_ENTRIES);
  localparam int PTE_W  = FRAME_W + 1;

  back_state_t state, state_next;

  logic [PAGE_W-1:0]      clr_addr;
  logic [PAGE_W-1:0]      cur_page;
  logic [OFFSET_BITS-1:0] cur_off;

  logic [PAGE_W-1:0]      tlb_tag   [TLB_ENTRIES];
  logic [FRAME_W-1:0]     tlb_frame [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid;
  logic [TIDX_W-1:0]      tlb_slot;

  logic [FRAME_W-1:0]     next_frame;
  logic [COUNT_W-1:0]     hit_count;
  logic [COUNT_W-1:0]     fault_count;

  logic                   tlb_match;
  logic [FRAME_W-1:0]     match_frame;
  logic                   pt_valid;
  logic [FRAME_W-1:0]     pt_frame;
  logic [FRAME_W-1:0]     res_frame;
  logic                   resolving;
  logic                   install;
  logic                   fault_now;

  logic                   pt_we;
  logic [PAGE_W-1:0]      pt_waddr;
  logic [PTE_W-1:0]       pt_wdata;
  logic [PTE_W-1:0]       pt_rdata;

  logic [FRAME_W+OFFSET_BITS-1:0] phys_full;

  tlbpt_ram #(
    .WIDTH(PTE_W),
    .DEPTH(PAGE_COUNT)
  ) u_page_table (
    .clk  (clk),
    .we   (pt_we),
    .waddr(pt_waddr),
    .wdata(pt_wdata),
    .raddr(head_page),
    .rdata(pt_rdata)
  );

  // highest matching index wins
  always_comb begin
    tlb_match   = 1'b0;
    match_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (tlb_valid[i] && (tlb_tag[i] == cur_page)) begin
        tlb_match   = 1'b1;
        match_frame = tlb_frame[i];
      end
    end
  end

  assign pt_valid  = pt_rdata[FRAME_W];
  assign pt_frame  = pt_rdata[FRAME_W-1:0];
  assign resolving = (state == ST_RESOLVE);
  assign install   = resolving && !tlb_match;
  assign fault_now = install && !pt_valid;
  assign res_frame = tlb_match ? match_frame : (pt_valid ? pt_frame : next_frame);
  assign phys_full = {res_frame, cur_off};

  assign hit_total   = hit_count;
  assign fault_total = fault_count;

  always_comb begin
    state_next      = state;
    status.pop      = 1'b0;
    status.clearing = 1'b0;
    pt_we           = 1'b0;
    pt_waddr        = cur_page;
    pt_wdata        = {1'b1, next_frame};
    case (state)
      ST_CLEAR: begin
        status.clearing = 1'b1;
        pt_we           = 1'b1;
        pt_waddr        = clr_addr;
        pt_wdata        = '0;
        if (clr_addr == PAGE_W'(PAGE_COUNT - 1)) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (head_valid) begin
          status.pop = 1'b1;
          state_next = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        pt_we      = fault_now;
        state_next = ST_FETCH;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (status.pop) begin
      cur_page <= head_page;
      cur_off  <= head_offset;
    end
    if (resolving) begin
      paddr        <= ADDR_W'(phys_full);
      frame_number <= res_frame;
      tlb_hit      <= tlb_match;
      page_fault   <= fault_now;
    end
    if (install) begin
      tlb_tag[tlb_slot]   <= cur_page;
      tlb_frame[tlb_slot] <= res_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      tlb_valid   <= '0;
      tlb_slot    <= '0;
      next_frame  <= '0;
      hit_count   <= '0;
      fault_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= resolving;
      if (status.clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (install) begin
        tlb_valid[tlb_slot] <= 1'b1;
        if (tlb_slot == TIDX_W'(TLB_ENTRIES - 1)) begin
          tlb_slot <= '0;
        end else begin
          tlb_slot <= tlb_slot + 1'b1;
        end
      end
      if (resolving && tlb_match && (hit_count != COUNT_MAX)) begin
        hit_count <= hit_count + 1'b1;
      end
      if (fault_now) begin
        next_frame <= next_frame + 1'b1;
        if (fault_count != COUNT_MAX) begin
          fault_count <= fault_count + 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_done_spacing: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe on two consecutive cycles");

  a_no_pt_write_on_hit: assert property (@(posedge clk) disable iff (rst)
    (resolving && tlb_match) |-> !pt_we)
    else $error("page table written on a TLB hit");

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> !status.pop)
    else $error("transaction popped during page table clear");

  a_frame_alloc_step: assert property (@(posedge clk) disable iff (rst)
    fault_now |=> (next_frame == FRAME_W'($past(next_frame) + 1'b1)))
    else $error("free frame pointer did not advance on a fault");
`endif

endmodule

/* rtl/core/tlb_page_table_translate.sv */
// TLB plus demand-paged page table address translator.
// Command channel: drive vaddr with start high; the transaction is
// taken on a rising edge where start is high and busy is low. The upper bits
// are the page (mod PAGE_COUNT), the low OFFSET_BITS bits the offset.
// Result channel: done pulses for one cycle with paddr,
// frame_number, tlb_hit, page_fault and the saturating hit_total and
// fault_total. Results come back in order, one per transaction; there is no
// backpressure, so the receiver must take each result in its strobe cycle.
// When the back end is idle, done follows the accepting edge through the second
// page-number stage, the queue write, the page table read and the resolve.
// The back end takes one transaction at a time: the page table RAM's
// registered read, then the resolve/write state. Up to 4 transactions
// may be buffered ahead of the back end; busy rises when that budget is used.
// Reset: TLB valid bits, FIFO pointers, free frame pointer and counters clear
// at once; then all PAGE_COUNT page table entries are swept clear with busy
// held high before the first transaction is taken.
module tlb_page_table_translate
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [ADDR_W-1:0]  vaddr,
  output logic               done,
  output logic [ADDR_W-1:0]  paddr,
  output logic [FRAME_W-1:0] frame_number,
  output logic               tlb_hit,
  output logic               page_fault,
  output logic [COUNT_W-1:0] hit_total,
  output logic [COUNT_W-1:0] fault_total
);

  localparam int PAGE_W = $clog2(PAGE_COUNT);

  logic                   head_valid;
  logic [PAGE_W-1:0]      head_page;
  logic [OFFSET_BITS-1:0] head_offset;
  back_status_t           status;

  tlbpt_front #(
    .PAGE_COUNT (PAGE_COUNT),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .vaddr      (vaddr),
    .head_valid (head_valid),
    .head_page  (head_page),
    .head_offset(head_offset),
    .status     (status)
  );

  tlbpt_back #(
    .TLB_ENTRIES(TLB_ENTRIES),
    .PAGE_COUNT (PAGE_COUNT),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_page   (head_page),
    .head_offset (head_offset),
    .status      (status),
    .done        (done),
    .paddr       (paddr),
    .frame_number(frame_number),
    .tlb_hit     (tlb_hit),
    .page_fault  (page_fault),
    .hit_total   (hit_total),
    .fault_total (fault_total)
  );

endmodule
